>>> sv/lcba_pkg.sv
// ----------------------------------------------------------------------------
// lcba_pkg
// Shared types and constants for the logical channel buffer accounting unit.
// ----------------------------------------------------------------------------
package lcba_pkg;

  localparam logic [31:0] HEADER_BYTES = 32'd4;
  localparam logic [31:0] SAT_MAX      = 32'hFFFF_FFFF;
  localparam int unsigned MAX_RESULTS  = 16;
  localparam int unsigned RES_CNT_W    = $clog2(MAX_RESULTS);
  localparam int unsigned DIR_W        = 16;
  localparam int unsigned DIR_CHANNELS = 8;

  // Register index, taken from paddr bit 2.
  localparam logic REG_CHANNEL_DIRECTIONS = 1'b0;

  typedef enum logic [2:0] {
    OP_SET_DL    = 3'd0,
    OP_SET_UL    = 3'd1,
    OP_ADD_UL    = 3'd2,
    OP_UL_RX     = 3'd3,
    OP_ALLOCATE  = 3'd4,
    OP_CLEAR     = 3'd5
  } lcba_op_e;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UL   = 2'd1,
    DIR_DL   = 2'd2,
    DIR_BOTH = 2'd3
  } lcba_dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_TAKE,
    ST_TOTALS,
    ST_EMIT
  } lcba_state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  channel;
    logic [31:0] amount_bytes;
    logic [31:0] retx_amount_bytes;
  } lcba_req_t;

  typedef struct packed {
    logic        pdu_valid;
    logic [2:0]  pdu_channel;
    logic [31:0] pdu_bytes;
    logic        last_result;
    logic [31:0] pending_dl_total;
    logic [31:0] pending_ul_total;
  } lcba_rsp_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic exec;       // apply a single-channel op
    logic grab;       // register take amount at current channel
    logic apply;      // subtract take from count and budget
    logic idx_inc;    // advance search pointer
    logic tot_clr;    // start totals scan
    logic tot_step;   // accumulate one channel
    logic restore;    // return pointer to last grabbed channel
    logic emit;
    logic emit_pdu;
    logic emit_last;
  } lcba_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic op_alloc;
    logic hit;
    logic idx_last;
    logic rem_zero;
    logic any_data;
  } lcba_sts_t;

  function automatic logic is_ul(logic [1:0] d);
    return (d == DIR_UL) || (d == DIR_BOTH);
  endfunction

  function automatic logic is_dl(logic [1:0] d);
    return (d == DIR_DL) || (d == DIR_BOTH);
  endfunction

endpackage

>>> sv/lcba_ctrl.sv
// ----------------------------------------------------------------------------
// lcba_ctrl
// Sequencer: operation execute, allocation search/grab, totals scan, emit.
// ----------------------------------------------------------------------------
module lcba_ctrl import lcba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  lcba_sts_t sts_i,
  output lcba_cmd_t cmd_o,
  output logic      busy_o
);

  lcba_state_e           state_q, state_d;
  logic [RES_CNT_W-1:0]  n_q, n_d;
  logic                  pdu_q, pdu_d;
  logic                  last;

  localparam logic [RES_CNT_W-1:0] LAST_N = RES_CNT_W'(MAX_RESULTS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      pdu_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      pdu_q   <= pdu_d;
    end
  end

  assign last = !pdu_q || sts_i.rem_zero || (n_q == LAST_N) || !sts_i.any_data;

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    pdu_d   = pdu_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          n_d        = '0;
          pdu_d      = 1'b0;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.op_alloc && !sts_i.rem_zero) begin
          state_d = ST_SEARCH;
        end else begin
          cmd_o.exec    = !sts_i.op_alloc;
          cmd_o.tot_clr = 1'b1;
          state_d       = ST_TOTALS;
        end
      end
      ST_SEARCH: begin
        if (sts_i.hit) begin
          cmd_o.grab = 1'b1;
          state_d    = ST_TAKE;
        end else if (sts_i.idx_last) begin
          // no data anywhere: empty result
          cmd_o.tot_clr = 1'b1;
          pdu_d         = 1'b0;
          state_d       = ST_TOTALS;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_TAKE: begin
        cmd_o.apply   = 1'b1;
        cmd_o.tot_clr = 1'b1;
        pdu_d         = 1'b1;
        state_d       = ST_TOTALS;
      end
      ST_TOTALS: begin
        cmd_o.tot_step = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_pdu  = pdu_q;
        cmd_o.emit_last = last;
        if (last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.restore = 1'b1;
          n_d           = n_q + 1'b1;
          state_d       = ST_SEARCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/lcba_dpath.sv
// ----------------------------------------------------------------------------
// lcba_dpath
// Per-channel byte counts, op arithmetic, grab logic and totals accumulators.
// ----------------------------------------------------------------------------
module lcba_dpath import lcba_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lcba_req_t        req_i,
  input  logic [DIR_W-1:0] dirs_i,
  input  lcba_cmd_t        cmd_i,
  output lcba_sts_t        sts_o,
  output logic             result_valid_o,
  output lcba_rsp_t        result_o
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  logic [31:0] new_q  [NUM_CHANNELS];
  logic [31:0] retx_q [NUM_CHANNELS];
  logic [31:0] ul_q   [NUM_CHANNELS];
  logic [1:0]  dir_a  [NUM_CHANNELS];

  logic [2:0]       op_q;
  logic             ch_ok_q;
  logic [31:0]      amt_q;      // budget left / length / amount
  logic [31:0]      retx_amt_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] pdu_ch_q;
  logic             from_retx_q;
  logic [31:0]      take_q;
  logic [31:0]      dl_acc_q;
  logic [31:0]      ul_acc_q;
  logic             any_q;

  logic [31:0] rd_new, rd_retx, rd_ul, cnt_sel;
  logic [1:0]  rd_dir;
  logic [32:0] ul_add;
  logic [33:0] dl_sum;
  logic [32:0] ul_sum;
  logic        hit;

  // Channels past the register width read as idle.
  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_dir
    if (i < DIR_CHANNELS) begin : g_reg
      assign dir_a[i] = dirs_i[2*i +: 2];
    end else begin : g_idle
      assign dir_a[i] = DIR_IDLE;
    end
  end

  assign rd_new  = new_q[idx_q];
  assign rd_retx = retx_q[idx_q];
  assign rd_ul   = ul_q[idx_q];
  assign rd_dir  = dir_a[idx_q];
  assign hit     = (rd_retx != '0) || (rd_new != '0);
  assign cnt_sel = (rd_retx != '0) ? rd_retx : rd_new;
  assign ul_add  = {1'b0, rd_ul} + {1'b0, amt_q};
  assign dl_sum  = {2'b00, dl_acc_q} + {2'b00, rd_new} + {2'b00, rd_retx};
  assign ul_sum  = {1'b0, ul_acc_q} + {1'b0, rd_ul};

  // Count storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        new_q[i]  <= '0;
        retx_q[i] <= '0;
        ul_q[i]   <= '0;
      end
    end else begin
      if (cmd_i.exec && ch_ok_q) begin
        case (op_q)
          OP_SET_DL: begin
            new_q[idx_q]  <= amt_q;
            retx_q[idx_q] <= retx_amt_q;
          end
          OP_SET_UL: ul_q[idx_q] <= amt_q;
          OP_ADD_UL: ul_q[idx_q] <= ul_add[32] ? SAT_MAX : ul_add[31:0];
          OP_UL_RX: begin
            if (is_ul(rd_dir)) begin
              ul_q[idx_q] <= (rd_ul > amt_q) ? (rd_ul - amt_q) : '0;
            end
          end
          OP_CLEAR: begin
            new_q[idx_q]  <= '0;
            retx_q[idx_q] <= '0;
            ul_q[idx_q]   <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.apply) begin
        if (from_retx_q) begin
          retx_q[idx_q] <= rd_retx - take_q;
        end else begin
          new_q[idx_q] <= rd_new - take_q;
        end
      end
    end
  end

  // Request capture, pointer, grab
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= (req_i.op == OP_ALLOCATE) ? '0 : IDX_W'(req_i.channel);
    end else if (cmd_i.restore) begin
      idx_q <= pdu_ch_q;
    end else if (cmd_i.tot_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc || (cmd_i.tot_step && (idx_q != LAST_IDX))) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= req_i.op;
      ch_ok_q    <= (5'(req_i.channel) < 5'(NUM_CHANNELS));
      retx_amt_q <= req_i.retx_amount_bytes;
      if (req_i.op == OP_UL_RX && req_i.amount_bytes > HEADER_BYTES) begin
        amt_q <= req_i.amount_bytes - HEADER_BYTES;
      end else begin
        amt_q <= req_i.amount_bytes;
      end
    end else if (cmd_i.apply) begin
      amt_q <= amt_q - take_q;
    end
    if (cmd_i.grab) begin
      from_retx_q <= (rd_retx != '0);
      take_q      <= (cnt_sel < amt_q) ? cnt_sel : amt_q;
      pdu_ch_q    <= idx_q;
    end
  end

  // Totals scan: saturating sums plus a flag for any data left
  always_ff @(posedge clk_i) begin
    if (cmd_i.tot_clr) begin
      dl_acc_q <= '0;
      ul_acc_q <= '0;
      any_q    <= 1'b0;
    end else if (cmd_i.tot_step) begin
      if (is_dl(rd_dir)) begin
        dl_acc_q <= (dl_sum[33:32] != 2'b00) ? SAT_MAX : dl_sum[31:0];
      end
      if (is_ul(rd_dir)) begin
        ul_acc_q <= ul_sum[32] ? SAT_MAX : ul_sum[31:0];
      end
      any_q <= any_q | hit;
    end
  end

  assign sts_o.op_alloc = (op_q == OP_ALLOCATE);
  assign sts_o.hit      = hit;
  assign sts_o.idx_last = (idx_q == LAST_IDX);
  assign sts_o.rem_zero = (amt_q == '0);
  assign sts_o.any_data = any_q;

  assign result_valid_o            = cmd_i.emit;
  assign result_o.pdu_valid        = cmd_i.emit_pdu;
  assign result_o.pdu_channel      = cmd_i.emit_pdu ? 3'(pdu_ch_q) : 3'd0;
  assign result_o.pdu_bytes        = cmd_i.emit_pdu ? take_q : '0;
  assign result_o.last_result      = cmd_i.emit_last;
  assign result_o.pending_dl_total = dl_acc_q;
  assign result_o.pending_ul_total = ul_acc_q;

endmodule

>>> sv/logical_channel_buffer_accounting_unit.sv
// ----------------------------------------------------------------------------
// logical_channel_buffer_accounting_unit
// Per-channel downlink/uplink byte accounting with budget allocation.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the last result of that request has been shown. Results appear on
// result_o for exactly one cycle each, marked by result_valid_o, and the
// receiver cannot stall them. The totals scan reads one channel per cycle
// from the count store. After the accept edge a non-allocate request passes
// an execute state and a totals scan over all NUM_CHANNELS channels, then
// shows its result in the next cycle; busy is low again in the cycle after
// the result. An allocate request passes the same execute state and then,
// per PDU, a lowest-channel search over up to NUM_CHANNELS channels (the
// search resumes where the previous grab left off, and the cycle that finds
// data also registers the grab), an update state, a totals scan and a
// result; at most 16 PDUs come from one request. The channel direction
// register lies at byte address 0 on the APB port and must only be written
// while busy is low.
// ----------------------------------------------------------------------------
module logical_channel_buffer_accounting_unit import lcba_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start,
  output logic        busy,
  input  lcba_req_t   req_i,
  // results
  output logic        result_valid_o,
  output lcba_rsp_t   result_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lcba_cmd_t        cmd;
  lcba_sts_t        sts;
  logic [DIR_W-1:0] dirs_q;
  logic             cfg_wr;

  // APB register: two direction bits per channel
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CHANNEL_DIRECTIONS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirs_q <= '0;
    end else if (cfg_wr) begin
      dirs_q <= pwdata[DIR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CHANNEL_DIRECTIONS) ? {16'd0, dirs_q} : 32'd0;

  lcba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  lcba_dpath #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .dirs_i        (dirs_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule
